[design/nlfsr_cipher_fixed_point_filter_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point filter unit
// Concurrent checks, reset-qualified, reported through $error.
// ----------------------------------------------------------------------------
`ifndef NLFSR_CIPHER_FIXED_POINT_FILTER_UNIT_ASSERT_SVH
`define NLFSR_CIPHER_FIXED_POINT_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication
`define NFPF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nfpf: same-cycle check failed");

// Next-cycle implication
`define NFPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nfpf: next-cycle check failed");

`endif

[design/nfpf_pkg.sv]
// ----------------------------------------------------------------------------
// nfpf_pkg
// Constants, stage types and round functions of the fixed-point filter unit.
// ----------------------------------------------------------------------------
package nfpf_pkg;

   localparam int ROUNDS      = 528;
   localparam int CELL_ROUNDS = 8;
   localparam int NUM_CELLS   = (ROUNDS + CELL_ROUNDS - 1) / CELL_ROUNDS;
   localparam int CNT_W       = $clog2(CELL_ROUNDS + 1);
   localparam int KEY_W       = 64;
   localparam int STATE_W     = 32;
   localparam int HALF_W      = STATE_W / 2;
   localparam int PEEL_ROUNDS = 16;
   localparam int PEEL_CELLS  = PEEL_ROUNDS / CELL_ROUNDS;

   localparam logic [31:0] NLF_TABLE = 32'h3A5C742E;

   typedef struct packed {
      logic               valid;
      logic [STATE_W-1:0] start;
      logic [STATE_W-1:0] state;
   } stage_type;

   typedef struct packed {
      logic                   valid;
      logic [STATE_W-1:0]     start;
      logic [STATE_W-1:0]     cipher;
      logic [STATE_W-1:0]     state;
      logic [PEEL_ROUNDS-1:0] key_bits;
   } peel_type;

   function automatic logic nlf_bit(input logic [STATE_W-1:0] s);
      logic [4:0] idx;
      idx = {s[31], s[26], s[20], s[9], s[1]};
      return NLF_TABLE[idx];
   endfunction

   function automatic logic [STATE_W-1:0] enc_round(input logic [STATE_W-1:0] s,
                                                    input logic kb);
      logic fb;
      fb = nlf_bit(s) ^ kb ^ s[16] ^ s[0];
      return {fb, s[STATE_W-1:1]};
   endfunction

endpackage

[design/nlfsr_cipher_fixed_point_filter_unit.sv]
// ----------------------------------------------------------------------------
// nlfsr_cipher_fixed_point_filter_unit
// Takes one plaintext request per cycle unless req_stall is raised, encrypts
// it for ROUNDS rounds of the 32-bit NLFSR cipher (528 by default), keeps
// only those whose low ciphertext half equals the high plaintext half, and
// recovers 16 key bits for each. The path runs through the chain of 8-round
// cells, two 8-round key recovery cells and the response register. Requests
// that fail the filter leave no response. While a response waits under
// rsp_stall the whole chain holds and req_stall is raised. The user must see
// that the key is written through the csr port only while the chain is empty;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "nlfsr_cipher_fixed_point_filter_unit_assert.svh"

module nlfsr_cipher_fixed_point_filter_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [nfpf_pkg::KEY_W-1:0]     csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [nfpf_pkg::STATE_W-1:0]   req_plaintext,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [nfpf_pkg::STATE_W-1:0]   rsp_start_state,
   output logic [nfpf_pkg::STATE_W-1:0]   rsp_cipher_out,
   output logic [nfpf_pkg::PEEL_ROUNDS-1:0] rsp_peeled_key_low
);
   import nfpf_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic             advance;
   logic             pass;

   stage_type round_d [NUM_CELLS];
   stage_type round_q [NUM_CELLS];
   peel_type  peel_d  [PEEL_CELLS];
   peel_type  peel_q  [PEEL_CELLS];
   peel_type  rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en) begin
         key_ff <= csr_wr_data;
      end
   end

   // whole chain freezes while a response is held
   assign advance   = !(rsp_ff.valid && rsp_stall);
   assign req_stall = !advance;

   genvar k;
   generate
      for (k = 0; k < NUM_CELLS; k++) begin : g_round
         localparam int KeyBase = (k * CELL_ROUNDS) % KEY_W;
         localparam int Left    = ROUNDS - k * CELL_ROUNDS;
         localparam int Cnt     = (Left < CELL_ROUNDS) ? Left : CELL_ROUNDS;

         if (k == 0) begin : g_first
            always_comb begin
               round_d[k].valid = req_valid;
               round_d[k].start = req_plaintext;
               round_d[k].state = req_plaintext;
            end
         end else begin : g_next
            assign round_d[k] = round_q[k-1];
         end

         nfpf_round_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (advance),
            .key_slice  (key_ff[KeyBase +: CELL_ROUNDS]),
            .num_rounds (CNT_W'(Cnt)),
            .stage_d    (round_d[k]),
            .stage_q    (round_q[k])
         );
      end

      for (k = 0; k < PEEL_CELLS; k++) begin : g_peel
         if (k == 0) begin : g_first
            always_comb begin
               peel_d[k].valid    = round_q[NUM_CELLS-1].valid && pass;
               peel_d[k].start    = round_q[NUM_CELLS-1].start;
               peel_d[k].cipher   = round_q[NUM_CELLS-1].state;
               peel_d[k].state    = round_q[NUM_CELLS-1].start;
               peel_d[k].key_bits = '0;
            end
         end else begin : g_next
            assign peel_d[k] = peel_q[k-1];
         end

         nfpf_peel_cell u_peel (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .fb_bits (peel_d[k].cipher[HALF_W + k*CELL_ROUNDS +: CELL_ROUNDS]),
            .peel_d  (peel_d[k]),
            .peel_q  (peel_q[k])
         );
      end
   endgenerate

   assign pass = round_q[NUM_CELLS-1].state[HALF_W-1:0]
              == round_q[NUM_CELLS-1].start[STATE_W-1:HALF_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (advance) begin
         rsp_ff.valid <= peel_q[PEEL_CELLS-1].valid;
      end
      if (advance) begin
         rsp_ff.start    <= peel_q[PEEL_CELLS-1].start;
         rsp_ff.cipher   <= peel_q[PEEL_CELLS-1].cipher;
         rsp_ff.state    <= peel_q[PEEL_CELLS-1].state;
         rsp_ff.key_bits <= peel_q[PEEL_CELLS-1].key_bits;
      end
   end

   assign rsp_valid          = rsp_ff.valid;
   assign rsp_start_state    = rsp_ff.start;
   assign rsp_cipher_out     = rsp_ff.cipher;
   assign rsp_peeled_key_low = rsp_ff.key_bits;

   `NFPF_ASSERT_IMPLY(a_rsp_fixed_point, clock, reset, rsp_valid, rsp_cipher_out[HALF_W-1:0] == rsp_start_state[STATE_W-1:HALF_W])
   `NFPF_ASSERT_IMPLY(a_peel_fixed_point, clock, reset, peel_q[0].valid, peel_q[0].cipher[HALF_W-1:0] == peel_q[0].start[STATE_W-1:HALF_W])
   `NFPF_ASSERT_NEXT(a_chain_frozen, clock, reset, req_stall, $stable(round_q[0]) && $stable(peel_q[PEEL_CELLS-1]))

endmodule

[design/nfpf_round_cell.sv]
// ----------------------------------------------------------------------------
// nfpf_round_cell
// One link of the encryption chain: up to CELL_ROUNDS rounds, then a register.
// ----------------------------------------------------------------------------
module nfpf_round_cell (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     advance,
   input  logic [nfpf_pkg::CELL_ROUNDS-1:0]         key_slice,
   input  logic [nfpf_pkg::CNT_W-1:0]               num_rounds,
   input  nfpf_pkg::stage_type                      stage_d,
   output nfpf_pkg::stage_type                      stage_q
);
   import nfpf_pkg::*;

   stage_type stage_ff;
   stage_type stage_in;
   logic [STATE_W-1:0] s;

   always_comb begin
      s = stage_d.state;
      for (int i = 0; i < CELL_ROUNDS; i++) begin
         if (i < int'(num_rounds)) begin
            s = enc_round(s, key_slice[i]);
         end
      end
      stage_in       = stage_d;
      stage_in.state = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.start <= stage_in.start;
         stage_ff.state <= stage_in.state;
      end
   end

   assign stage_q = stage_ff;

endmodule

[design/nfpf_peel_cell.sv]
// ----------------------------------------------------------------------------
// nfpf_peel_cell
// One link of the key recovery tail: replays CELL_ROUNDS rounds with known
// feedback and shifts the recovered key bits in from the top.
// ----------------------------------------------------------------------------
module nfpf_peel_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [nfpf_pkg::CELL_ROUNDS-1:0] fb_bits,
   input  nfpf_pkg::peel_type               peel_d,
   output nfpf_pkg::peel_type               peel_q
);
   import nfpf_pkg::*;

   peel_type peel_ff;
   peel_type peel_in;
   logic [STATE_W-1:0]     s;
   logic [CELL_ROUNDS-1:0] kb;

   always_comb begin
      s  = peel_d.state;
      kb = '0;
      for (int i = 0; i < CELL_ROUNDS; i++) begin
         kb[i] = fb_bits[i] ^ nlf_bit(s) ^ s[16] ^ s[0];
         s     = {fb_bits[i], s[STATE_W-1:1]};
      end
      peel_in          = peel_d;
      peel_in.state    = s;
      // newest bits enter at the top, earlier ones move down
      peel_in.key_bits = {kb, peel_d.key_bits[PEEL_ROUNDS-1:CELL_ROUNDS]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peel_ff.valid <= 1'b0;
      end else if (advance) begin
         peel_ff.valid <= peel_in.valid;
      end
      if (advance) begin
         peel_ff.start    <= peel_in.start;
         peel_ff.cipher   <= peel_in.cipher;
         peel_ff.state    <= peel_in.state;
         peel_ff.key_bits <= peel_in.key_bits;
      end
   end

   assign peel_q = peel_ff;

endmodule

[bench/tb_nlfsr_cipher_fixed_point_filter_unit.sv]
// ----------------------------------------------------------------------------
// tb_nlfsr_cipher_fixed_point_filter_unit
// Self-checking bench for the fixed-point filter unit. A scoreboard class
// encrypts every accepted plaintext under the current key and queues the
// survivors, then compares each response field by field in order. Random
// phases mostly run under keys built so that a chosen plaintext is a fixed
// point of 64 rounds, which makes survivors common enough to check.
// ----------------------------------------------------------------------------
module tb_nlfsr_cipher_fixed_point_filter_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import nfpf_pkg::*;

   localparam int          ITEM_TARGET     = 1350;
   localparam int          DRAIN_CYCLES    = NUM_CELLS + PEEL_CELLS + 1 + 8;
   localparam int          LONG_HOLD       = 400;
   localparam int          WATCHDOG_CYCLES = 4000;
   localparam int          PRESSURE_PHASE  = 2;
   localparam logic [63:0] KEY_ZERO        = 64'h0;
   localparam logic [63:0] KEY_ONES        = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum int {
      KEY_KIND_ZERO,
      KEY_KIND_ONES,
      KEY_KIND_RANDOM,
      KEY_KIND_FIXED_POINT
   } key_kind_type;

   typedef struct packed {
      logic [STATE_W-1:0]     start_state;
      logic [STATE_W-1:0]     cipher_out;
      logic [PEEL_ROUNDS-1:0] peeled_key_low;
   } survivor_type;

   class survivor_board_type;
      logic [KEY_W-1:0] cipher_key;
      survivor_type     pending[$];
      int unsigned      mismatches;

      function new();
         cipher_key = '0;
         mismatches = 0;
      endfunction

      function logic feedback_tap(input logic [STATE_W-1:0] s);
         logic [4:0] idx;
         idx = {s[31], s[26], s[20], s[9], s[1]};
         return NLF_TABLE[idx];
      endfunction

      function logic [STATE_W-1:0] encrypt_rounds(input logic [STATE_W-1:0] pt);
         logic [STATE_W-1:0] s;
         logic               fb;
         s = pt;
         for (int r = 0; r < ROUNDS; r++) begin
            fb = feedback_tap(s) ^ cipher_key[r % 64] ^ s[16] ^ s[0];
            s  = {fb, s[STATE_W-1:1]};
         end
         return s;
      endfunction

      // replay from the start state, taking the upper ciphertext half as the
      // feedback of the first rounds, and solve each round for its key bit
      function logic [PEEL_ROUNDS-1:0] recover_key_bits(input logic [STATE_W-1:0] pt,
                                                        input logic [STATE_W-1:0] ct);
         logic [STATE_W-1:0]     s;
         logic [PEEL_ROUNDS-1:0] bits;
         logic                   fb;
         s = pt;
         bits = '0;
         for (int r = 0; r < PEEL_ROUNDS; r++) begin
            fb      = ct[HALF_W + r];
            bits[r] = fb ^ feedback_tap(s) ^ s[16] ^ s[0];
            s       = {fb, s[STATE_W-1:1]};
         end
         return bits;
      endfunction

      // key under which pt returns to itself after 64 rounds; such a start
      // state passes the filter for any round count of 512 plus 16
      function logic [KEY_W-1:0] fixed_point_key(input logic [STATE_W-1:0] pt,
                                                 input logic [STATE_W-1:0] lead);
         logic [STATE_W-1:0] s;
         logic [KEY_W-1:0]   k;
         logic               fb;
         s = pt;
         k = '0;
         for (int r = 0; r < 64; r++) begin
            fb   = (r < 32) ? lead[r] : pt[r-32];
            k[r] = fb ^ feedback_tap(s) ^ s[16] ^ s[0];
            s    = {fb, s[STATE_W-1:1]};
         end
         return k;
      endfunction

      function void note_plaintext(input logic [STATE_W-1:0] pt);
         survivor_type       want;
         logic [STATE_W-1:0] ct;
         ct = encrypt_rounds(pt);
         if (ct[HALF_W-1:0] == pt[STATE_W-1:HALF_W]) begin
            want.start_state    = pt;
            want.cipher_out     = ct;
            want.peeled_key_low = recover_key_bits(pt, ct);
            pending.push_back(want);
         end
      endfunction

      function void check_survivor(input survivor_type got);
         survivor_type want;
         if (pending.size() == 0) begin
            $error("unexpected response: start_state %h cipher_out %h",
                   got.start_state, got.cipher_out);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (got.start_state !== want.start_state) begin
            $error("start_state: expected %h, actual %h", want.start_state, got.start_state);
            mismatches++;
         end
         if (got.cipher_out !== want.cipher_out) begin
            $error("cipher_out: expected %h, actual %h", want.cipher_out, got.cipher_out);
            mismatches++;
         end
         if (got.peeled_key_low !== want.peeled_key_low) begin
            $error("peeled_key_low: expected %h, actual %h",
                   want.peeled_key_low, got.peeled_key_low);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [KEY_W-1:0]       csr_wr_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [STATE_W-1:0]     req_plaintext;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [STATE_W-1:0]     rsp_start_state;
   logic [STATE_W-1:0]     rsp_cipher_out;
   logic [PEEL_ROUNDS-1:0] rsp_peeled_key_low;

   survivor_board_type board = new();

   bit          quiet_phase;
   bit          hold_off_req;
   bit          rsp_taken;
   int unsigned stall_left;
   int unsigned idle_cycles;
   int unsigned items_sent;

   nlfsr_cipher_fixed_point_filter_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_plaintext      (req_plaintext),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_start_state    (rsp_start_state),
      .rsp_cipher_out     (rsp_cipher_out),
      .rsp_peeled_key_low (rsp_peeled_key_low)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // monitors and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            board.note_plaintext(req_plaintext);
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_survivor({rsp_start_state, rsp_cipher_out, rsp_peeled_key_low});
            rsp_taken   = 1'b1;
            idle_cycles = 0;
         end
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("tb_nlfsr_cipher_fixed_point_filter_unit NOT OK");
            $finish;
         end
      end
   end

   // response side: a drawn hold-off after each response taken, or one long one
   always @(negedge clock) begin
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         stall_left   = LONG_HOLD;
      end else if (rsp_taken) begin
         rsp_taken  = 1'b0;
         stall_left = quiet_phase ? 0 : $urandom_range(0, 11);
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_plaintext(input logic [STATE_W-1:0] pt);
      int unsigned gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_plaintext <= pt;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
   endtask

   task automatic drain_chain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      // requests that fail the filter may still be in the chain
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_key(input logic [KEY_W-1:0] k);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      board.cipher_key = k;
   endtask

   task automatic run_phase(input int phase);
      key_kind_type       kind;
      logic [STATE_W-1:0] fp;
      logic [KEY_W-1:0]   k;
      int unsigned        n;
      int unsigned        pick;
      case ($urandom_range(0, 7))
         0:       kind = KEY_KIND_ZERO;
         1:       kind = KEY_KIND_ONES;
         2:       kind = KEY_KIND_RANDOM;
         default: kind = KEY_KIND_FIXED_POINT;
      endcase
      if (phase == PRESSURE_PHASE) kind = KEY_KIND_FIXED_POINT;
      fp = $urandom;
      case (kind)
         KEY_KIND_ZERO: begin
            k  = KEY_ZERO;
            fp = '0;
         end
         KEY_KIND_ONES: begin
            k  = KEY_ONES;
            fp = '1;
         end
         KEY_KIND_RANDOM: begin
            k = {$urandom, $urandom};
         end
         default: begin
            k = board.fixed_point_key(fp, $urandom);
         end
      endcase
      drain_chain();
      write_key(k);
      quiet_phase = ($urandom_range(0, 3) == 0);
      if (phase == PRESSURE_PHASE) begin
         // one survivor waits under a long hold-off while the chain fills
         quiet_phase = 1'b1;
         send_plaintext(fp);
         hold_off_req = 1'b1;
         repeat (200) send_plaintext($urandom);
      end else begin
         n = $urandom_range(16, 40);
         for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
               repeat ($urandom_range(1, 4)) send_plaintext(fp);
            end else if (pick == 2) begin
               // near miss: same high half as the survivor
               send_plaintext({fp[STATE_W-1:HALF_W], HALF_W'($urandom)});
            end else begin
               send_plaintext($urandom);
            end
         end
      end
   endtask

   initial begin
      logic [STATE_W-1:0] fp;
      int                 phase;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_valid     = 1'b0;
      req_plaintext = '0;
      rsp_stall     = 1'b0;
      quiet_phase   = 1'b1;
      hold_off_req  = 1'b0;
      rsp_taken     = 1'b0;
      stall_left    = 0;
      idle_cycles   = 0;
      items_sent    = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // key at its reset value: all-zero plaintext is a fixed point
      send_plaintext(32'h0000_0000);
      send_plaintext(32'hFFFF_FFFF);
      send_plaintext(32'h0000_FFFF);
      send_plaintext(32'hFFFF_0000);
      send_plaintext(32'h8000_0000);
      send_plaintext(32'h0000_0001);
      send_plaintext(32'hAAAA_AAAA);
      send_plaintext(32'h5555_5555);

      // all-ones key: all-ones plaintext is a fixed point
      drain_chain();
      write_key(KEY_ONES);
      send_plaintext(32'hFFFF_FFFF);
      send_plaintext(32'h0000_0000);
      send_plaintext(32'hAAAA_AAAA);
      send_plaintext(32'h5555_5555);
      send_plaintext(32'hFFFF_0000);

      drain_chain();
      write_key(KEY_ZERO);
      send_plaintext(32'h0000_0000);
      send_plaintext(32'h0001_0000);

      fp = $urandom;
      drain_chain();
      write_key(board.fixed_point_key(fp, $urandom));
      send_plaintext(fp);
      send_plaintext(fp ^ 32'h0000_0001);
      send_plaintext(fp ^ 32'h8000_0000);
      send_plaintext(fp);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         run_phase(phase);
         phase++;
      end

      quiet_phase = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("tb_nlfsr_cipher_fixed_point_filter_unit OK");
      end else begin
         $display("tb_nlfsr_cipher_fixed_point_filter_unit NOT OK");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/nfpf_pkg.sv
design/nfpf_round_cell.sv
design/nfpf_peel_cell.sv
design/nlfsr_cipher_fixed_point_filter_unit.sv
bench/tb_nlfsr_cipher_fixed_point_filter_unit.sv
